### rtl/assert_macros.svh
// Assertion helpers, clocked on i_clk; CHECK_ALWAYS is held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge out of reset.
`define CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked including the reset cycles.
`define CHECK_RESET(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/elsc_pkg.sv
package elsc_pkg;

    // Field widths fixed by the interface
    localparam int FLOOR_W = 4;
    localparam int SLOT_W  = 4;

    localparam int DEF_NUM_FLOORS = 10;
    localparam int DEF_CAR_SLOTS  = 10;
    localparam int DEF_HALL_SLOTS = 16;

    // Request kinds
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Result actions
    typedef enum logic [2:0] {
        ACT_ADDED    = 3'd0,
        ACT_REJECTED = 3'd1,
        ACT_UNLOADED = 3'd2,
        ACT_LOADED   = 3'd3,
        ACT_IDLE     = 3'd4,
        ACT_UP       = 3'd5,
        ACT_DOWN     = 3'd6
    } t_action;

endpackage

### rtl/elsc_hall_mem.sv
module elsc_hall_mem #(
    parameter int DEPTH = elsc_pkg::DEF_NUM_FLOORS * elsc_pkg::DEF_HALL_SLOTS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [elsc_pkg::FLOOR_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [elsc_pkg::FLOOR_W-1:0] o_rd_data
);

    logic [elsc_pkg::FLOOR_W-1:0] r_mem [DEPTH];

    // Hall destinations, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### rtl/elsc_occ.sv
module elsc_occ #(
    parameter int NUM_FLOORS = elsc_pkg::DEF_NUM_FLOORS,
    parameter int HALL_SLOTS = elsc_pkg::DEF_HALL_SLOTS,
    parameter int FIW        = $clog2(NUM_FLOORS),
    parameter int HW         = (HALL_SLOTS > 1) ? $clog2(HALL_SLOTS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [FIW-1:0]        i_row,
    input  logic                  i_set_en,
    input  logic [FIW-1:0]        i_set_row,
    input  logic [HW-1:0]         i_set_slot,
    input  logic                  i_clr_en,
    input  logic [HW-1:0]         i_clr_slot,
    output logic [HALL_SLOTS-1:0] o_row_bits,
    output logic [HW-1:0]         o_free_slot,
    output logic                  o_full,
    output logic [NUM_FLOORS-1:0] o_wait_vec
);

    logic [HALL_SLOTS-1:0] r_occ [NUM_FLOORS];

    // Occupied bit per hall entry; a clear bit reads as an empty slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_FLOORS; k++) begin
                r_occ[k] <= '0;
            end
        end else begin
            if (i_set_en) begin
                r_occ[i_set_row][i_set_slot] <= 1'b1;
            end
            if (i_clr_en) begin
                r_occ[i_row][i_clr_slot] <= 1'b0;
            end
        end
    end

    // Row view, lowest free slot, per-floor waiting flags
    always_comb begin
        o_row_bits  = r_occ[i_row];
        o_full      = &o_row_bits;
        o_free_slot = '0;
        for (int s = HALL_SLOTS - 1; s >= 0; s--) begin
            if (!o_row_bits[s]) begin
                o_free_slot = HW'(s);
            end
        end
        for (int k = 0; k < NUM_FLOORS; k++) begin
            o_wait_vec[k] = |r_occ[k];
        end
    end

endmodule

### rtl/elevator_look_scheduler.sv
// LOOK elevator scheduler, one car.
// Input channel: i_in_valid / o_in_stall carry one request per transaction:
//   i_req_type 0 adds a waiting passenger (i_origin_floor, i_target_floor),
//   i_req_type 1 runs one scheduling step.
// Output channel: o_out_valid / i_out_stall carry exactly one result per
//   request: action, car floor and direction, slots used, rider destination.
// Sequence: an add goes straight to emit, a step that unloads via judge,
//   an idle step via judge and decide, a move via judge, decide and move. A
//   scan of the floor's hall slots comes after judge (one slot a cycle on the
//   memory read port). A re-judge scans once more at most, as the second scan
//   always finds a passenger.
// One request is in work at a time; o_in_stall is high while it is.
// A finished result waits in its own stage, so the next request is taken
//   while the output register is still held by a stalling receiver.
// Reset (synchronous, active low) clears the car slots, empties hall slots
//   through the occupied bits at once, parks the car on floor 1 heading up,
//   drops o_out_valid. No clearing pass is needed.
module elevator_look_scheduler #(
    parameter int NUM_FLOORS = elsc_pkg::DEF_NUM_FLOORS,
    parameter int CAR_SLOTS  = elsc_pkg::DEF_CAR_SLOTS,
    parameter int HALL_SLOTS = elsc_pkg::DEF_HALL_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [elsc_pkg::FLOOR_W-1:0] i_origin_floor,
    input  logic [elsc_pkg::FLOOR_W-1:0] i_target_floor,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_action,
    output logic [elsc_pkg::FLOOR_W-1:0] o_car_floor,
    output logic                         o_heading_down,
    output logic [elsc_pkg::SLOT_W-1:0]  o_car_slot_used,
    output logic [elsc_pkg::SLOT_W-1:0]  o_hall_slot_used,
    output logic [elsc_pkg::FLOOR_W-1:0] o_rider_dest
);

    localparam int FW    = elsc_pkg::FLOOR_W;
    localparam int SW    = elsc_pkg::SLOT_W;
    localparam int FIW   = $clog2(NUM_FLOORS);
    localparam int CW    = (CAR_SLOTS > 1) ? $clog2(CAR_SLOTS) : 1;
    localparam int HW    = (HALL_SLOTS > 1) ? $clog2(HALL_SLOTS) : 1;
    localparam int HCW   = $clog2(HALL_SLOTS + 1);
    localparam int DEPTH = NUM_FLOORS * HALL_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [FW-1:0]  TOP_FLOOR = FW'(NUM_FLOORS);
    localparam logic [FW-1:0]  GROUND    = FW'(1);
    localparam logic [HCW-1:0] SCAN_END  = HCW'(HALL_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_JUDGE, ST_SCAN, ST_DECIDE, ST_MOVE, ST_EMIT
    } t_state;

    t_state             r_state;
    logic [FW-1:0]      r_cur_floor;
    logic               r_down;
    logic [FW-1:0]      r_car [CAR_SLOTS];
    logic [1:0]         r_pass;
    logic [CW-1:0]      r_free_car;
    logic [HCW-1:0]     r_scan_idx;
    logic               r_chk_valid;
    logic [HW-1:0]      r_chk_idx;
    elsc_pkg::t_action  r_res_action;
    logic [SW-1:0]      r_res_car;
    logic [SW-1:0]      r_res_hall;
    logic [FW-1:0]      r_res_dest;

    // Occupancy and memory hookup
    logic [FIW-1:0]        row_idx;
    logic [FW-1:0]         origin_m1;
    logic [FW-1:0]         cur_m1;
    logic                  add_ok_range;
    logic [HALL_SLOTS-1:0] row_bits;
    logic [HW-1:0]         free_hall;
    logic                  row_full;
    logic [NUM_FLOORS-1:0] wait_vec;
    logic                  occ_set;
    logic                  occ_clr;
    logic [AW-1:0]         row_base;
    logic                  rd_en;
    logic [FW-1:0]         rd_data;
    logic                  in_accept;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall   = (r_state != ST_IDLE);
    assign origin_m1    = i_origin_floor - GROUND;
    assign cur_m1       = r_cur_floor - GROUND;
    assign add_ok_range = (i_origin_floor >= GROUND) && (i_origin_floor <= TOP_FLOOR)
                       && (i_target_floor >= GROUND) && (i_target_floor <= TOP_FLOOR)
                       && (i_target_floor != i_origin_floor);
    assign row_idx  = (r_state == ST_IDLE) ? (add_ok_range ? origin_m1[FIW-1:0] : '0)
                                           : cur_m1[FIW-1:0];
    assign row_base = AW'(row_idx) * AW'(HALL_SLOTS);
    assign rd_en    = (r_state == ST_SCAN) && (r_scan_idx != SCAN_END);

    elsc_occ #(
        .NUM_FLOORS (NUM_FLOORS),
        .HALL_SLOTS (HALL_SLOTS),
        .FIW        (FIW),
        .HW         (HW)
    ) u_occ (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row       (row_idx),
        .i_set_en    (occ_set),
        .i_set_row   (row_idx),
        .i_set_slot  (free_hall),
        .i_clr_en    (occ_clr),
        .i_clr_slot  (r_chk_idx),
        .o_row_bits  (row_bits),
        .o_free_slot (free_hall),
        .o_full      (row_full),
        .o_wait_vec  (wait_vec)
    );

    elsc_hall_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (occ_set),
        .i_wr_addr (row_base + AW'(free_hall)),
        .i_wr_data (i_target_floor),
        .i_rd_en   (rd_en),
        .i_rd_addr (row_base + AW'(r_scan_idx)),
        .o_rd_data (rd_data)
    );

    // Car slot search: highest rider for this floor, lowest empty slot
    logic          unl_hit;
    logic [CW-1:0] unl_idx;
    logic          car_has_free;
    logic [CW-1:0] car_free_idx;
    logic          car_empty;

    always_comb begin
        unl_hit      = 1'b0;
        unl_idx      = '0;
        car_has_free = 1'b0;
        car_free_idx = '0;
        car_empty    = 1'b1;
        for (int i = 0; i < CAR_SLOTS; i++) begin
            if (r_car[i] == r_cur_floor) begin
                unl_hit = 1'b1;
                unl_idx = CW'(i);
            end
            if (r_car[i] != '0) begin
                car_empty = 1'b0;
            end
        end
        for (int i = CAR_SLOTS - 1; i >= 0; i--) begin
            if (r_car[i] == '0) begin
                car_has_free = 1'b1;
                car_free_idx = CW'(i);
            end
        end
    end

    // Waiting above, below and here
    logic wait_up;
    logic wait_dn;
    logic wait_here;

    always_comb begin
        wait_up   = 1'b0;
        wait_dn   = 1'b0;
        wait_here = 1'b0;
        for (int k = 0; k < NUM_FLOORS; k++) begin
            if (wait_vec[k]) begin
                if (FW'(k + 1) > r_cur_floor) begin
                    wait_up = 1'b1;
                end
                if (FW'(k + 1) < r_cur_floor) begin
                    wait_dn = 1'b1;
                end
                if (FW'(k + 1) == r_cur_floor) begin
                    wait_here = 1'b1;
                end
            end
        end
    end

    // Scan check on the registered memory word
    logic load_hit;
    assign load_hit = (r_state == ST_SCAN) && r_chk_valid && row_bits[r_chk_idx]
                   && (rd_data != '0)
                   && (r_down ? (rd_data < r_cur_floor) : (rd_data > r_cur_floor));
    assign occ_set  = in_accept && (i_req_type == elsc_pkg::REQ_ADD) && add_ok_range
                   && !row_full;
    assign occ_clr  = load_hit;

    // Move: turn at the end floors before and after stepping
    logic          mv_down;
    logic [FW-1:0] mv_floor;
    logic          mv_down_after;

    always_comb begin
        mv_down = r_down;
        if (!r_down && (r_cur_floor >= TOP_FLOOR)) begin
            mv_down = 1'b1;
        end else if (r_down && (r_cur_floor <= GROUND)) begin
            mv_down = 1'b0;
        end
        mv_floor      = mv_down ? (r_cur_floor - GROUND) : (r_cur_floor + GROUND);
        mv_down_after = mv_down;
        if (mv_floor >= TOP_FLOOR) begin
            mv_down_after = 1'b1;
        end
        if (mv_floor <= GROUND) begin
            mv_down_after = 1'b0;
        end
    end

    // Sequencer, car slots and result/output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_floor <= GROUND;
            r_down      <= 1'b0;
            r_pass      <= '0;
            r_chk_valid <= 1'b0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < CAR_SLOTS; i++) begin
                r_car[i] <= '0;
            end
        end else begin
            // Output drains; the emit stage owns the flag while it loads
            if (o_out_valid && !i_out_stall && (r_state != ST_EMIT)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (i_req_type == elsc_pkg::REQ_ADD) begin
                            r_res_car <= '0;
                            if (occ_set) begin
                                r_res_action <= elsc_pkg::ACT_ADDED;
                                r_res_hall   <= SW'(free_hall);
                                r_res_dest   <= i_target_floor;
                            end else begin
                                r_res_action <= elsc_pkg::ACT_REJECTED;
                                r_res_hall   <= '0;
                                r_res_dest   <= '0;
                            end
                            r_state <= ST_EMIT;
                        end else begin
                            r_pass  <= '0;
                            r_state <= ST_JUDGE;
                        end
                    end
                end
                ST_JUDGE: begin
                    if (unl_hit) begin
                        r_car[unl_idx] <= '0;
                        r_res_action   <= elsc_pkg::ACT_UNLOADED;
                        r_res_car      <= SW'(unl_idx);
                        r_res_hall     <= '0;
                        r_res_dest     <= r_cur_floor;
                        r_state        <= ST_EMIT;
                    end else if (car_has_free && (|row_bits)) begin
                        r_free_car  <= car_free_idx;
                        r_scan_idx  <= '0;
                        r_chk_valid <= 1'b0;
                        r_state     <= ST_SCAN;
                    end else begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_SCAN: begin
                    r_chk_valid <= rd_en;
                    r_chk_idx   <= r_scan_idx[HW-1:0];
                    if (rd_en) begin
                        r_scan_idx <= r_scan_idx + HCW'(1);
                    end
                    if (load_hit) begin
                        r_car[r_free_car] <= rd_data;
                        r_res_action      <= elsc_pkg::ACT_LOADED;
                        r_res_car         <= SW'(r_free_car);
                        r_res_hall        <= SW'(r_chk_idx);
                        r_res_dest        <= rd_data;
                        r_state           <= ST_EMIT;
                    end else if (!rd_en && !r_chk_valid) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (!car_empty) begin
                        r_state <= ST_MOVE;
                    end else if (!wait_up && !wait_dn && !wait_here) begin
                        r_res_action <= elsc_pkg::ACT_IDLE;
                        r_res_car    <= '0;
                        r_res_hall   <= '0;
                        r_res_dest   <= '0;
                        r_state      <= ST_EMIT;
                    end else if ((!r_down && !wait_up) || (r_down && !wait_dn)) begin
                        r_down <= !r_down;
                        if (wait_here && (r_pass != 2'd2)) begin
                            r_pass  <= r_pass + 2'd1;
                            r_state <= ST_JUDGE;
                        end else begin
                            r_state <= ST_MOVE;
                        end
                    end else begin
                        r_state <= ST_MOVE;
                    end
                end
                ST_MOVE: begin
                    r_cur_floor  <= mv_floor;
                    r_down       <= mv_down_after;
                    r_res_action <= mv_down ? elsc_pkg::ACT_DOWN : elsc_pkg::ACT_UP;
                    r_res_car    <= '0;
                    r_res_hall   <= '0;
                    r_res_dest   <= '0;
                    r_state      <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid      <= 1'b1;
                        o_action         <= r_res_action;
                        o_car_floor      <= r_cur_floor;
                        o_heading_down   <= r_down;
                        o_car_slot_used  <= r_res_car;
                        o_hall_slot_used <= r_res_hall;
                        o_rider_dest     <= r_res_dest;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`include "assert_macros.svh"

    `CHECK_ALWAYS(a_floor_range, (r_cur_floor >= GROUND) && (r_cur_floor <= TOP_FLOOR), "car floor out of range")
    `CHECK_ALWAYS(a_busy_after_accept, in_accept |=> (r_state != ST_IDLE), "request accepted but sequencer idle")
    `CHECK_ALWAYS(a_load_dest, (o_out_valid && (o_action == elsc_pkg::ACT_LOADED)) |-> (o_rider_dest != '0), "load with empty destination")
    `CHECK_RESET(a_reset_idle, !i_rst_n |=> !o_out_valid && (r_state == ST_IDLE), "reset left block busy")

endmodule
